@@ sv/ept_pkg.sv @@
// Shared types and constants of the execution path coverage tracker.
`default_nettype none
package ept_pkg;

  localparam int RING_DEPTH_DEF       = 5;
  localparam int RUN_SET_DEPTH_DEF    = 1024;
  localparam int GLOBAL_SET_DEPTH_DEF = 4096;

  localparam logic [63:0] DJB_SEED = 64'd5381;
  localparam logic [31:0] MIX_LO   = 32'h7F4A7C15;
  localparam logic [31:0] MIX_HI   = 32'h9E3779B9;

  localparam int EPOCH_W     = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_LOG   = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;
  localparam logic [1:0] CMD_SEED  = 2'd3;

  typedef enum logic [1:0] {
    OP_START,
    OP_LOG,
    OP_END,
    OP_SEED
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [63:0] addr;
    logic        crashed;
  } op_t;

endpackage
`default_nettype wire

@@ sv/execution_path_coverage_tracker.sv @@
// Top level of the execution path coverage tracker; a two-entry queue feeds the back end.
// Log: byte-serial path fold alongside a run set insert with linear probing.
// Start: resets the run state, plus a run set clear every 16th start.
// End: strobe once every unique run address is inserted into the global set and, on a crash,
//   ring entries are folded into the crash hash; a non-power-of-2 set depth adds a modulo per insert.
// After reset busy stays high while the run and global set memories are cleared.
`default_nettype none
module execution_path_coverage_tracker #(
  parameter int RING_DEPTH       = ept_pkg::RING_DEPTH_DEF,
  parameter int RUN_SET_DEPTH    = ept_pkg::RUN_SET_DEPTH_DEF,
  parameter int GLOBAL_SET_DEPTH = ept_pkg::GLOBAL_SET_DEPTH_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start,
  output logic              busy,
  input  wire logic [1:0]   cmd_i,
  input  wire logic [63:0]  block_addr_i,
  input  wire logic         crashed_i,
  output logic              done_o,
  output logic [63:0]       path_hash_o,
  output logic [63:0]       crash_hash_o,
  output logic [10:0]       unique_count_o,
  output logic [12:0]       new_count_o,
  output logic              set_overflow_o
);

  ept_pkg::op_t push_op, head_op;
  logic         push, pop, q_empty, q_full, init_busy;

  assign busy = q_full || init_busy;

  ept_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .cmd_i        (cmd_i),
    .block_addr_i (block_addr_i),
    .crashed_i    (crashed_i),
    .op_o         (push_op),
    .push_o       (push)
  );

  ept_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .op_i    (push_op),
    .pop_i   (pop),
    .op_o    (head_op),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  ept_back #(
    .RING_DEPTH       (RING_DEPTH),
    .RUN_SET_DEPTH    (RUN_SET_DEPTH),
    .GLOBAL_SET_DEPTH (GLOBAL_SET_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_i           (head_op),
    .empty_i        (q_empty),
    .pop_o          (pop),
    .init_busy_o    (init_busy),
    .done_o         (done_o),
    .path_hash_o    (path_hash_o),
    .crash_hash_o   (crash_hash_o),
    .unique_count_o (unique_count_o),
    .new_count_o    (new_count_o),
    .set_overflow_o (set_overflow_o)
  );

endmodule
`default_nettype wire

@@ sv/ept_front.sv @@
// Command front end: tracks the run state and classifies accepted transactions.
`default_nettype none
module ept_front (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         start_i,
  input  wire logic         busy_i,
  input  wire logic [1:0]   cmd_i,
  input  wire logic [63:0]  block_addr_i,
  input  wire logic         crashed_i,
  output ept_pkg::op_t      op_o,
  output logic              push_o
);

  logic run_active_q, run_active_d;
  logic accept;

  assign accept = start_i && !busy_i;

  always_comb begin
    run_active_d = run_active_q;
    push_o       = 1'b0;
    op_o.addr    = block_addr_i;
    op_o.crashed = crashed_i;
    op_o.op      = ept_pkg::OP_SEED;
    case (cmd_i)
      ept_pkg::CMD_START: begin
        op_o.op = ept_pkg::OP_START;
        push_o  = accept;
        if (accept) run_active_d = 1'b1;
      end
      ept_pkg::CMD_LOG: begin
        op_o.op = ept_pkg::OP_LOG;
        push_o  = accept && run_active_q;
      end
      ept_pkg::CMD_END: begin
        op_o.op = ept_pkg::OP_END;
        push_o  = accept && run_active_q;
        if (accept) run_active_d = 1'b0;
      end
      default: begin
        op_o.op = ept_pkg::OP_SEED;
        push_o  = accept;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_active_q <= 1'b0;
    end else begin
      run_active_q <= run_active_d;
    end
  end

endmodule
`default_nettype wire

@@ sv/ept_queue.sv @@
// Short queue of classified operations between front end and back end.
`default_nettype none
module ept_queue (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire ept_pkg::op_t op_i,
  input  wire logic         pop_i,
  output ept_pkg::op_t      op_o,
  output logic              empty_o,
  output logic              full_o
);

  localparam int Depth = ept_pkg::QUEUE_DEPTH;
  localparam int AW    = $clog2(Depth);
  localparam int CW    = $clog2(Depth + 1);

  ept_pkg::op_t   mem_q [Depth];
  logic [AW-1:0]  wp_q, rp_q;
  logic [CW-1:0]  cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CW'(Depth));
  assign op_o    = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= op_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
      if (pop_i)  rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
      cnt_q <= cnt_q + CW'(push_i) - CW'(pop_i);
    end
  end

endmodule
`default_nettype wire

@@ sv/ept_back.sv @@
// Back end: path hash, recent ring, run and global address sets, run end report.
`default_nettype none
module ept_back #(
  parameter int RING_DEPTH       = ept_pkg::RING_DEPTH_DEF,
  parameter int RUN_SET_DEPTH    = ept_pkg::RUN_SET_DEPTH_DEF,
  parameter int GLOBAL_SET_DEPTH = ept_pkg::GLOBAL_SET_DEPTH_DEF
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire ept_pkg::op_t op_i,
  input  wire logic         empty_i,
  output logic              pop_o,
  output logic              init_busy_o,
  output logic              done_o,
  output logic [63:0]       path_hash_o,
  output logic [63:0]       crash_hash_o,
  output logic [10:0]       unique_count_o,
  output logic [12:0]       new_count_o,
  output logic              set_overflow_o
);

  localparam int MaxDepth = (RUN_SET_DEPTH > GLOBAL_SET_DEPTH) ? RUN_SET_DEPTH
                                                                : GLOBAL_SET_DEPTH;
  localparam int IW  = $clog2(MaxDepth);
  localparam int MW  = IW + 2;
  localparam int CW  = IW + 1;
  localparam int RIW = $clog2(RUN_SET_DEPTH);
  localparam int GIW = $clog2(GLOBAL_SET_DEPTH);
  localparam int RSW = $clog2(RUN_SET_DEPTH + 1);
  localparam int GSW = $clog2(GLOBAL_SET_DEPTH + 1);
  localparam int PW  = $clog2(RING_DEPTH);
  localparam int EW  = ept_pkg::EPOCH_W;
  localparam bit RunPow2  = (RUN_SET_DEPTH & (RUN_SET_DEPTH - 1)) == 0;
  localparam bit GlobPow2 = (GLOBAL_SET_DEPTH & (GLOBAL_SET_DEPTH - 1)) == 0;
  localparam int RunL  = $clog2(RUN_SET_DEPTH);
  localparam int GlobL = $clog2(GLOBAL_SET_DEPTH);
  localparam logic [63:0] RunRecip =
    ((64'd1 << (32 + RunL)) + 64'(RUN_SET_DEPTH) - 64'd1) / 64'(RUN_SET_DEPTH);
  localparam logic [63:0] GlobRecip =
    ((64'd1 << (32 + GlobL)) + 64'(GLOBAL_SET_DEPTH) - 64'd1) / 64'(GLOBAL_SET_DEPTH);

  typedef enum logic [11:0] {
    S_INIT  = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_H0    = 12'b000000000100,
    S_H1    = 12'b000000001000,
    S_H2    = 12'b000000010000,
    S_MOD   = 12'b000000100000,
    S_RD    = 12'b000001000000,
    S_CHK   = 12'b000010000000,
    S_MRD   = 12'b000100000000,
    S_MLD   = 12'b001000000000,
    S_CRASH = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_e;

  typedef struct packed {
    logic [EW-1:0] tag;
    logic [63:0]   addr;
  } run_ent_t;

  state_e          state_q, state_d;
  ept_pkg::op_e    opc_q, opc_d;
  logic            crashed_q, crashed_d;
  logic [63:0]     key_q, key_d;
  logic            tgt_q, tgt_d;
  logic [63:0]     hacc_q, hacc_d;
  logic            mcnt_q, mcnt_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic [MW-1:0]   n_q, n_d;
  logic [RSW-1:0]  run_size_q, run_size_d;
  logic [GSW-1:0]  glob_size_q, glob_size_d;
  logic [EW-1:0]   epoch_q, epoch_d;
  logic            ovf_q, ovf_d;
  logic [GSW-1:0]  fresh_q, fresh_d;
  logic [RSW-1:0]  mi_q, mi_d;
  logic [63:0]     path_q, path_d;
  logic [63:0]     crash_q, crash_d;
  logic [3:0]      fcnt_q, fcnt_d;
  logic            fsel_q, fsel_d;
  logic [63:0]     fa_q, fa_d;
  logic [63:0]     ring_q [RING_DEPTH];
  logic [63:0]     ring_d [RING_DEPTH];
  logic [PW-1:0]   pos_q, pos_d;
  logic [PW-1:0]   ck_q, ck_d;
  logic [PW-1:0]   ci_q, ci_d;
  logic [CW-1:0]   clr_q, clr_d;
  logic            clr_glob_q, clr_glob_d;
  logic            done_d;
  logic [63:0]     path_out_d, crash_out_d;
  logic [10:0]     uniq_out_d;
  logic [12:0]     new_out_d;
  logic            ovf_out_d;

  run_ent_t        run_mem [RUN_SET_DEPTH];
  logic [63:0]     glob_mem [GLOBAL_SET_DEPTH];
  logic [63:0]     list_mem [RUN_SET_DEPTH];
  run_ent_t        run_rd_q;
  logic [63:0]     glob_rd_q;
  logic [63:0]     list_rd_q;

  logic            run_we, glob_we, list_we;
  logic [RIW-1:0]  run_wa;
  logic [GIW-1:0]  glob_wa;
  run_ent_t        run_wd;
  logic [63:0]     glob_wd;

  logic [31:0]     mul_a, mul_b;
  logic [63:0]     prod;
  logic [31:0]     h32;
  logic [MW-1:0]   dsel;
  logic            pow2sel;
  logic [32:0]     recip;
  logic [5:0]      rsh;
  logic [65:0]     rprod;
  logic [63:0]     qd;
  logic [63:0]     fh, fnew;
  logic            ent_empty, ent_hit, full_sel;
  logic [63:0]     ent_addr;
  logic            ins_fin, ins_new;
  logic [PW-1:0]   kn;

  assign dsel    = tgt_q ? MW'(GLOBAL_SET_DEPTH) : MW'(RUN_SET_DEPTH);
  assign pow2sel = tgt_q ? GlobPow2 : RunPow2;
  assign recip   = tgt_q ? GlobRecip[32:0] : RunRecip[32:0];
  assign rsh     = tgt_q ? 6'(32 + GlobL) : 6'(32 + RunL);

  always_comb begin
    mul_a = key_q[31:0];
    mul_b = ept_pkg::MIX_LO;
    if (state_q == S_H1) mul_a = key_q[63:32];
    if (state_q == S_H2) mul_b = ept_pkg::MIX_HI;
  end
  assign prod = mul_a * mul_b;
  assign h32  = hacc_q[31:0] + prod[31:0];

  assign rprod = {34'd0, hacc_q[31:0]} * {33'd0, recip};
  assign qd    = {32'd0, hacc_q[63:32]} * 64'(dsel);

  assign fh   = fsel_q ? crash_q : path_q;
  assign fnew = fh + (fh << 5) + {56'd0, fa_q[7:0]};

  assign ent_addr  = tgt_q ? glob_rd_q : run_rd_q.addr;
  assign ent_empty = tgt_q ? (glob_rd_q == '0)
                           : (run_rd_q.tag != epoch_q || run_rd_q.addr == '0);
  assign ent_hit   = !ent_empty && (ent_addr == key_q);
  assign full_sel  = tgt_q ? (glob_size_q >= GSW'(GLOBAL_SET_DEPTH))
                           : (run_size_q >= RSW'(RUN_SET_DEPTH));
  assign kn        = (ck_q == '0) ? PW'(RING_DEPTH - 1) : ck_q - 1'b1;

  always_comb begin
    state_d     = state_q;
    opc_d       = opc_q;
    crashed_d   = crashed_q;
    key_d       = key_q;
    tgt_d       = tgt_q;
    hacc_d      = hacc_q;
    mcnt_d      = mcnt_q;
    idx_d       = idx_q;
    n_d         = n_q;
    run_size_d  = run_size_q;
    glob_size_d = glob_size_q;
    epoch_d     = epoch_q;
    ovf_d       = ovf_q;
    fresh_d     = fresh_q;
    mi_d        = mi_q;
    path_d      = path_q;
    crash_d     = crash_q;
    fcnt_d      = fcnt_q;
    fsel_d      = fsel_q;
    fa_d        = fa_q;
    ring_d      = ring_q;
    pos_d       = pos_q;
    ck_d        = ck_q;
    ci_d        = ci_q;
    clr_d       = clr_q;
    clr_glob_d  = clr_glob_q;
    done_d      = 1'b0;
    path_out_d  = path_hash_o;
    crash_out_d = crash_hash_o;
    uniq_out_d  = unique_count_o;
    new_out_d   = new_count_o;
    ovf_out_d   = set_overflow_o;
    pop_o       = 1'b0;
    run_we      = 1'b0;
    glob_we     = 1'b0;
    list_we     = 1'b0;
    run_wa      = idx_q[RIW-1:0];
    glob_wa     = idx_q[GIW-1:0];
    run_wd      = '{tag: epoch_q, addr: key_q};
    glob_wd     = key_q;
    ins_fin     = 1'b0;
    ins_new     = 1'b0;

    // fold one byte per cycle into the selected hash
    if (fcnt_q != '0) begin
      if (fsel_q) crash_d = fnew;
      else        path_d  = fnew;
      fa_d   = fa_q >> 8;
      fcnt_d = fcnt_q - 1'b1;
    end

    case (state_q)
      S_INIT: begin
        run_we  = clr_q < CW'(RUN_SET_DEPTH);
        glob_we = clr_glob_q && (clr_q < CW'(GLOBAL_SET_DEPTH));
        run_wa  = clr_q[RIW-1:0];
        glob_wa = clr_q[GIW-1:0];
        run_wd  = '0;
        glob_wd = '0;
        clr_d   = clr_q + 1'b1;
        if (clr_q == (clr_glob_q ? CW'(MaxDepth - 1) : CW'(RUN_SET_DEPTH - 1))) begin
          clr_glob_d = 1'b0;
          state_d    = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!empty_i && fcnt_q == '0) begin
          pop_o = 1'b1;
          opc_d = op_i.op;
          key_d = op_i.addr;
          case (op_i.op)
            ept_pkg::OP_START: begin
              path_d     = ept_pkg::DJB_SEED;
              for (int i = 0; i < RING_DEPTH; i++) ring_d[i] = '0;
              pos_d      = '0;
              run_size_d = '0;
              epoch_d    = epoch_q + 1'b1;
              if (epoch_q == '1) begin
                clr_d   = '0;
                state_d = S_INIT;
              end
            end
            ept_pkg::OP_LOG: begin
              ring_d[pos_q] = op_i.addr;
              pos_d  = (pos_q == PW'(RING_DEPTH - 1)) ? '0 : pos_q + 1'b1;
              fsel_d = 1'b0;
              fa_d   = op_i.addr;
              fcnt_d = 4'd8;
              tgt_d  = 1'b0;
              if (op_i.addr != '0) state_d = S_H0;
            end
            ept_pkg::OP_END: begin
              crashed_d = op_i.crashed;
              crash_d   = ept_pkg::DJB_SEED;
              ck_d      = pos_q;
              ci_d      = '0;
              fresh_d   = '0;
              mi_d      = '0;
              state_d   = S_MRD;
            end
            default: begin
              tgt_d = 1'b1;
              if (op_i.addr != '0) state_d = S_H0;
            end
          endcase
        end
      end
      S_H0: begin
        hacc_d  = prod;
        state_d = S_H1;
      end
      S_H1: begin
        hacc_d  = {32'd0, hacc_q[63:32] + prod[31:0]};
        state_d = S_H2;
      end
      S_H2: begin
        n_d = '0;
        if (pow2sel) begin
          idx_d   = IW'(h32) & IW'(dsel - 1'b1);
          state_d = S_RD;
        end else begin
          hacc_d  = {32'd0, h32};
          mcnt_d  = 1'b0;
          state_d = S_MOD;
        end
      end
      S_MOD: begin
        if (!mcnt_q) begin
          hacc_d = {32'(rprod >> rsh), hacc_q[31:0]};
          mcnt_d = 1'b1;
        end else begin
          idx_d   = IW'(hacc_q[31:0] - qd[31:0]);
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_CHK;
      end
      S_CHK: begin
        if (ent_hit) begin
          ins_fin = 1'b1;
        end else if (ent_empty && !full_sel) begin
          ins_fin = 1'b1;
          ins_new = 1'b1;
          if (tgt_q) begin
            glob_we     = 1'b1;
            glob_size_d = glob_size_q + 1'b1;
          end else begin
            run_we     = 1'b1;
            list_we    = 1'b1;
            run_size_d = run_size_q + 1'b1;
          end
        end else if (ent_empty || n_q == dsel - 1'b1) begin
          ins_fin = 1'b1;
          ovf_d   = 1'b1;
        end else begin
          n_d     = n_q + 1'b1;
          idx_d   = (idx_q == IW'(dsel - 1'b1)) ? '0 : idx_q + 1'b1;
          state_d = S_RD;
        end
        if (ins_fin) begin
          if (opc_q == ept_pkg::OP_END) begin
            fresh_d = fresh_q + GSW'(ins_new);
            mi_d    = mi_q + 1'b1;
            state_d = S_MRD;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_MRD: begin
        if (mi_q == run_size_q) state_d = crashed_q ? S_CRASH : S_OUT;
        else                    state_d = S_MLD;
      end
      S_MLD: begin
        key_d   = list_rd_q;
        tgt_d   = 1'b1;
        state_d = S_H0;
      end
      S_CRASH: begin
        if (fcnt_q == '0) begin
          if (ci_q == PW'(RING_DEPTH - 1)) begin
            state_d = S_OUT;
          end else begin
            fsel_d = 1'b1;
            fa_d   = ring_q[kn];
            fcnt_d = 4'd8;
            ck_d   = kn;
            ci_d   = ci_q + 1'b1;
          end
        end
      end
      S_OUT: begin
        done_d      = 1'b1;
        path_out_d  = path_q;
        crash_out_d = crash_q;
        uniq_out_d  = 11'(run_size_q);
        new_out_d   = 13'(fresh_q);
        ovf_out_d   = ovf_q;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign init_busy_o = (state_q == S_INIT) && clr_glob_q;

  always_ff @(posedge clk_i) begin
    if (run_we) run_mem[run_wa] <= run_wd;
    run_rd_q <= run_mem[idx_q[RIW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (glob_we) glob_mem[glob_wa] <= glob_wd;
    glob_rd_q <= glob_mem[idx_q[GIW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (list_we) list_mem[run_size_q[RIW-1:0]] <= key_q;
    list_rd_q <= list_mem[mi_q[RIW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    opc_q     <= opc_d;
    crashed_q <= crashed_d;
    key_q     <= key_d;
    tgt_q     <= tgt_d;
    hacc_q    <= hacc_d;
    mcnt_q    <= mcnt_d;
    idx_q     <= idx_d;
    n_q       <= n_d;
    fresh_q   <= fresh_d;
    mi_q      <= mi_d;
    crash_q   <= crash_d;
    fsel_q    <= fsel_d;
    fa_q      <= fa_d;
    ck_q      <= ck_d;
    ci_q      <= ci_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_INIT;
      clr_q          <= '0;
      clr_glob_q     <= 1'b1;
      run_size_q     <= '0;
      glob_size_q    <= '0;
      epoch_q        <= '0;
      ovf_q          <= 1'b0;
      path_q         <= ept_pkg::DJB_SEED;
      fcnt_q         <= '0;
      pos_q          <= '0;
      for (int i = 0; i < RING_DEPTH; i++) ring_q[i] <= '0;
      done_o         <= 1'b0;
      path_hash_o    <= '0;
      crash_hash_o   <= '0;
      unique_count_o <= '0;
      new_count_o    <= '0;
      set_overflow_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      clr_q          <= clr_d;
      clr_glob_q     <= clr_glob_d;
      run_size_q     <= run_size_d;
      glob_size_q    <= glob_size_d;
      epoch_q        <= epoch_d;
      ovf_q          <= ovf_d;
      path_q         <= path_d;
      fcnt_q         <= fcnt_d;
      pos_q          <= pos_d;
      ring_q         <= ring_d;
      done_o         <= done_d;
      path_hash_o    <= path_out_d;
      crash_hash_o   <= crash_out_d;
      unique_count_o <= uniq_out_d;
      new_count_o    <= new_out_d;
      set_overflow_o <= ovf_out_d;
    end
  end

endmodule
`default_nettype wire

@@ sv/ept_checker.sv @@
// Port-level checks of the execution path coverage tracker and their binding.
`default_nettype none
module ept_checker #(
  parameter int RUN_SET_DEPTH = ept_pkg::RUN_SET_DEPTH_DEF
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        done_o,
  input wire logic [10:0] unique_count_o,
  input wire logic [12:0] new_count_o,
  input wire logic        set_overflow_o
);

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held for two cycles");

  a_overflow_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(set_overflow_o)) else $error("overflow flag cleared");

  a_new_le_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> new_count_o <= 13'(unique_count_o))
    else $error("more new addresses than unique ones");

  a_unique_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> 32'(unique_count_o) <= 32'(RUN_SET_DEPTH))
    else $error("unique count above run set depth");

endmodule

bind execution_path_coverage_tracker ept_checker #(
  .RUN_SET_DEPTH (RUN_SET_DEPTH)
) u_ept_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .done_o         (done_o),
  .unique_count_o (unique_count_o),
  .new_count_o    (new_count_o),
  .set_overflow_o (set_overflow_o)
);
`default_nettype wire
